// ===== rtl/ordered_list_append_delete_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block.
// The macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH

// The check must hold in the same cycle that the trigger is seen.
`define OLAD_ASSERT_IMPLY(name, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("ordered list check failed");

// The check must hold in the cycle after the trigger is seen.
`define OLAD_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("ordered list check failed");

`endif

// ===== rtl/olad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olad_pkg
// Shared sizes, codes and types of the ordered list block.
// ----------------------------------------------------------------------------
package olad_pkg;

  // Number of list cells.
  localparam int DEPTH   = 16;
  // Width of the fill count, which must reach DEPTH itself.
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic append_en;  // an append transfer is taken this cycle
    logic delete_en;  // a delete transfer is taken this cycle
    logic occupied;   // the cell holds a live entry
    logic is_tail;    // the cell is the first free place
  } cell_ctrl_t;

endpackage

// ===== rtl/ordered_list_append_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete_top
// Bounded ordered list of signed 32-bit values with append and delete.
// ----------------------------------------------------------------------------
// The block takes one operation per clock unless stalled and returns its status and the new
// entry count in the cycle after the input transfer, through an output register;
// a new input transfer is taken whenever that register is empty or is being
// emptied in the same cycle. The list is a row of DEPTH cells. On a delete
// every cell compares its entry with the key at once and a found flag ripples
// from head to tail through all cells, so that ripple sets the clock period.
// Appends to a full list are dropped with status 1; deletes that find nothing
// return status 2 and leave the list unchanged.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_top
  import olad_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic signed [VALUE_W-1:0]  in_item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [COUNT_W-1:0]         out_entry_count
);

  logic                      in_xfer;
  logic                      is_append;
  logic                      is_delete;
  logic                      full;
  logic                      found_any;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [STATUS_W-1:0]       status_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]        out_entry_count_r;
  logic                      found_chain [DEPTH+1];
  logic signed [VALUE_W-1:0] cell_value  [DEPTH];
  cell_ctrl_t                cell_ctrl   [DEPTH];

  // Input handshake: stall only while a finished result is held back.
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign is_append = in_xfer & (in_opcode == OP_APPEND);
  assign is_delete = in_xfer & (in_opcode == OP_DELETE);
  assign full      = (count_r == CNT_W'(DEPTH));

  // Row of cells, chained head to tail.
  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].append_en = is_append;
    assign cell_ctrl[i].delete_en = is_delete;
    assign cell_ctrl[i].occupied  = (count_r > CNT_W'(i));
    assign cell_ctrl[i].is_tail   = (count_r == CNT_W'(i));

    olad_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .key        (in_item_value),
      .found_in   (found_chain[i]),
      .next_value ((i == DEPTH - 1) ? cell_value[i] : cell_value[(i + 1) % DEPTH]),
      .found_out  (found_chain[i+1]),
      .value      (cell_value[i])
    );
  end

  assign found_any = found_chain[DEPTH];

  // Fill count and status of the operation.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_opcode == OP_APPEND) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (is_append) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (!found_any) begin
        status_nxt = ST_NOT_FOUND;
      end else if (is_delete) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Output register holds the result until its transfer.
  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r      <= status_nxt;
      out_entry_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  // Checks on the list controller.
`include "ordered_list_append_delete_top_assert.svh"

  `OLAD_ASSERT_IMPLY(a_count_in_range, 1'b1, count_r <= CNT_W'(DEPTH))
  `OLAD_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_r)
  `OLAD_ASSERT_NEXT(a_append_grows, is_append && !full, count_r == $past(count_r) + CNT_W'(1))
  `OLAD_ASSERT_NEXT(a_full_status, is_append && full, out_status_r == ST_FULL)
  `OLAD_ASSERT_NEXT(a_miss_keeps_count, is_delete && !found_any, count_r == $past(count_r))

endmodule

// ===== rtl/olad_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olad_cell
// One list cell: holds an entry, compares it with the search key, passes the
// found flag toward the tail and takes its neighbor's entry on a delete.
// ----------------------------------------------------------------------------
module olad_cell
  import olad_pkg::*;
(
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] key,
  input  logic                      found_in,
  input  logic signed [VALUE_W-1:0] next_value,
  output logic                      found_out,
  output logic signed [VALUE_W-1:0] value
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  // A match here or in any cell nearer the head marks the deletion point.
  assign found_out = found_in | (ctrl.occupied & (value_r == key));

  // Appends write the tail cell; a delete pulls every later entry one place up.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.append_en && ctrl.is_tail) begin
      value_nxt = key;
    end else if (ctrl.delete_en && ctrl.occupied && found_out) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule
